// ===== rtl/fpe_pkg.sv =====
`timescale 1ns / 1ps

package fpe_pkg;

    // table geometry
    localparam int MAX_FLOWS = 16;
    localparam int SLOT_W    = 4;
    localparam int CFG_W     = 5;
    localparam int CNT_W     = 32;
    localparam int LEN_W     = 32;
    localparam int KEY_W     = 104;
    localparam int TBL_W     = KEY_W + LEN_W;
    localparam int BIN_W     = 8;
    localparam int CADDR_W   = SLOT_W + BIN_W;

    localparam logic [CFG_W-1:0] FLOWS_MAX   = CFG_W'(MAX_FLOWS);
    localparam logic [CFG_W-1:0] FLOWS_RESET = CFG_W'(16);

    // header parsing
    localparam int EARLY_BYTES = 20;
    localparam int EARLY_W     = 5;
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam logic [6:0] TCP_HDR   = 7'd20;
    localparam logic [6:0] UDP_HDR   = 7'd8;

    // entropy arithmetic
    localparam int FRAC_BITS = 16;
    localparam int LOG_FRAC  = 24;
    localparam int LOG_K_W   = 5;
    localparam int LOG_W     = LOG_K_W + LOG_FRAC;
    localparam int SUM_W     = LOG_FRAC + 4;
    localparam int ENT_W     = 20;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       last_byte;
    } t_in_req;

    typedef struct packed {
        logic [ENT_W-1:0]  entropy_q16;
        logic [SLOT_W-1:0] flow_slot;
        logic              new_flow;
    } t_out_res;

    typedef struct packed {
        logic [31:0] saddr;
        logic [31:0] daddr;
        logic [7:0]  proto;
        logic [15:0] sport;
        logic [15:0] dport;
    } t_flow_key;

    typedef struct packed {
        logic             start;
        logic [LEN_W-1:0] len;
    } t_ent_req;

    typedef struct packed {
        logic             done;
        logic [ENT_W-1:0] q;
        logic             rd_en;
        logic [BIN_W-1:0] rd_idx;
    } t_ent_stat;

endpackage

// ===== rtl/fpe_ram.sv =====
`timescale 1ns / 1ps

module fpe_ram #(
    parameter int ADDR_W = 4,
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/fpe_log2.sv =====
`timescale 1ns / 1ps

module fpe_log2 import fpe_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [31:0]      i_value,
    output logic             o_done,
    output logic [LOG_W-1:0] o_log
);

    typedef enum logic [1:0] {L_IDLE, L_NORM, L_SQ} t_state;

    t_state               r_state;
    logic [31:0]          r_x;
    logic [LOG_K_W-1:0]   r_k;
    logic [LOG_FRAC-1:0]  r_frac;
    logic [LOG_K_W-1:0]   r_n;
    logic                 r_done;

    logic [63:0] sq;
    logic [32:0] sq_t;

    // one squaring step per cycle
    always_comb begin
        sq   = r_x * r_x;
        sq_t = sq[63:31];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
            r_k     <= '0;
            r_frac  <= '0;
            r_n     <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                L_IDLE: begin
                    if (i_start) begin
                        r_x     <= i_value;
                        r_k     <= LOG_K_W'(31);
                        r_state <= L_NORM;
                    end
                end
                // shift up to the leading one, one bit a cycle
                L_NORM: begin
                    if (r_x[31]) begin
                        r_n     <= '0;
                        r_frac  <= '0;
                        r_state <= L_SQ;
                    end else begin
                        r_x <= {r_x[30:0], 1'b0};
                        r_k <= r_k - 1'b1;
                    end
                end
                L_SQ: begin
                    r_frac <= {r_frac[LOG_FRAC-2:0], sq_t[32]};
                    r_x    <= sq_t[32] ? sq_t[32:1] : sq_t[31:0];
                    r_n    <= r_n + 1'b1;
                    if (r_n == LOG_K_W'(LOG_FRAC - 1)) begin
                        r_done  <= 1'b1;
                        r_state <= L_IDLE;
                    end
                end
                default: r_state <= L_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_log  = {r_k, r_frac};

endmodule

// ===== rtl/fpe_entropy.sv =====
`timescale 1ns / 1ps

module fpe_entropy import fpe_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_ent_req         i_req,
    input  logic [CNT_W-1:0] i_rd_data,
    output t_ent_stat        o_stat
);

    typedef enum logic [3:0] {
        E_IDLE, E_LOGL, E_RD, E_CHK, E_LOGC, E_MUL, E_DIV, E_ACC, E_RND
    } t_state;

    localparam int PROD_W   = CNT_W + LOG_W;
    localparam int ROUND_SH = LOG_FRAC - FRAC_BITS;
    localparam logic [SUM_W-1:0] SUM_CAP   = SUM_W'(8) << LOG_FRAC;
    localparam logic [SUM_W:0]   ROUND_ADD = (SUM_W + 1)'(1) << ROUND_SH;
    localparam logic [ENT_W-1:0] ENT_MAX   = '1;

    t_state              r_state;
    logic [LEN_W-1:0]    r_len;
    logic [LOG_W-1:0]    r_logl;
    logic [CNT_W-1:0]    r_c;
    logic [LOG_W-1:0]    r_d;
    logic [CNT_W-1:0]    r_rem;
    logic [LOG_W-1:0]    r_low;
    logic [LOG_W-1:0]    r_q;
    logic [LOG_K_W-1:0]  r_step;
    logic [BIN_W-1:0]    r_i;
    logic [SUM_W-1:0]    r_sum;
    logic                r_done;
    logic [ENT_W-1:0]    r_qout;

    logic             log_start;
    logic [31:0]      log_value;
    logic             log_done;
    logic [LOG_W-1:0] log_res;

    logic [PROD_W-1:0] prod;
    logic [CNT_W:0]    div_t;
    logic              div_ge;
    logic [CNT_W-1:0]  div_rem;
    logic [SUM_W+1:0]  acc;
    logic [SUM_W:0]    rnd;
    logic              skip;

    fpe_log2 u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (log_start),
        .i_value (log_value),
        .o_done  (log_done),
        .o_log   (log_res)
    );

    // term arithmetic: product, restoring divide step, saturating sum, rounding
    always_comb begin
        skip      = (i_rd_data == '0) || (i_rd_data >= r_len);
        log_start = ((r_state == E_IDLE) && i_req.start && (i_req.len != '0)) ||
                    ((r_state == E_CHK) && !skip);
        log_value = (r_state == E_IDLE) ? i_req.len : i_rd_data;
        prod      = PROD_W'(r_c) * PROD_W'(r_d);
        div_t     = {r_rem, r_low[LOG_W-1]};
        div_ge    = div_t >= {1'b0, r_len};
        div_rem   = div_ge ? CNT_W'(div_t - {1'b0, r_len}) : div_t[CNT_W-1:0];
        acc       = {2'b00, r_sum} + (SUM_W + 2)'(r_q);
        rnd       = ({r_sum, 1'b0} + ROUND_ADD) >> (ROUND_SH + 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_done  <= 1'b0;
            r_qout  <= '0;
            r_i     <= '0;
            r_sum   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                E_IDLE: begin
                    if (i_req.start) begin
                        r_len <= i_req.len;
                        r_sum <= '0;
                        r_i   <= '0;
                        r_state <= (i_req.len == '0) ? E_RND : E_LOGL;
                    end
                end
                E_LOGL: begin
                    if (log_done) begin
                        r_logl  <= log_res;
                        r_state <= E_RD;
                    end
                end
                E_RD: r_state <= E_CHK;
                // empty bins and a bin holding the whole flow add nothing
                E_CHK: begin
                    r_c <= i_rd_data;
                    if (!skip) begin
                        r_state <= E_LOGC;
                    end else if (r_i == '1) begin
                        r_state <= E_RND;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= E_RD;
                    end
                end
                E_LOGC: begin
                    if (log_done) begin
                        r_d     <= r_logl - log_res;
                        r_state <= E_MUL;
                    end
                end
                E_MUL: begin
                    r_rem   <= prod[PROD_W-1:LOG_W];
                    r_low   <= prod[LOG_W-1:0];
                    r_q     <= '0;
                    r_step  <= '0;
                    r_state <= E_DIV;
                end
                // one quotient bit per cycle
                E_DIV: begin
                    r_rem  <= div_rem;
                    r_low  <= {r_low[LOG_W-2:0], 1'b0};
                    r_q    <= {r_q[LOG_W-2:0], div_ge};
                    r_step <= r_step + 1'b1;
                    if (r_step == LOG_K_W'(LOG_W - 1)) begin
                        r_state <= E_ACC;
                    end
                end
                E_ACC: begin
                    r_sum <= (acc > (SUM_W + 2)'(SUM_CAP)) ? SUM_CAP : acc[SUM_W-1:0];
                    if (r_i == '1) begin
                        r_state <= E_RND;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= E_RD;
                    end
                end
                E_RND: begin
                    r_qout  <= (rnd > (SUM_W + 1)'(ENT_MAX)) ? ENT_MAX : rnd[ENT_W-1:0];
                    r_done  <= 1'b1;
                    r_state <= E_IDLE;
                end
                default: r_state <= E_IDLE;
            endcase
        end
    end

    always_comb begin
        o_stat.done   = r_done;
        o_stat.q      = r_qout;
        o_stat.rd_en  = (r_state == E_RD);
        o_stat.rd_idx = r_i;
    end

endmodule

// ===== rtl/flow_payload_entropy_top.sv =====
// Payload bytes after the lookup read their count, then write it back.
// Flow lookup compares one slot at a time; a new or never-used slot adds a sweep
// that clears its 256 counts, then counts each buffered payload byte.
// Packet end: entropy pass over 256 count bins; each bin that is neither empty nor
// the whole flow runs the log unit and a 29-step divider; then a one-cycle strobe.
// Synchronous active-low reset clears control and table valid bits; no clearing pass.
`timescale 1ns / 1ps

module flow_payload_entropy_top import fpe_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  t_in_req          i_req,
    output logic             busy,
    output logic             o_valid,
    output t_out_res         o_res,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    typedef enum logic [3:0] {
        S_IDLE, S_LK_RD, S_LK_CMP, S_CLR, S_EC, S_CNT_WR, S_FIN, S_ENT
    } t_state;

    t_state               r_state;
    logic [CFG_W-1:0]     r_cfg;
    logic [SLOT_W-1:0]    r_ptr;
    logic [15:0]          r_pos;
    logic [5:0]           r_hdr_len;
    t_flow_key            r_key;
    logic [7:0]           r_early [EARLY_BYTES];
    logic                 r_looked;
    logic [SLOT_W-1:0]    r_slot;
    logic                 r_new;
    logic [LEN_W-1:0]     r_len;
    logic [MAX_FLOWS-1:0] r_vld;
    logic                 r_last;
    logic                 r_in_early;
    logic [SLOT_W-1:0]    r_lk_idx;
    logic [6:0]           r_eidx;
    logic [EARLY_W-1:0]   r_lim;
    logic [BIN_W-1:0]     r_sweep;
    logic [CADDR_W-1:0]   r_wr_addr;
    logic                 r_out_valid;
    t_out_res             r_res;

    logic               accept;
    logic [7:0]         in_byte;
    t_flow_key          n_key;
    logic [5:0]         n_hdr_len;
    logic [15:0]        port_off;
    logic               is_ports;
    logic [6:0]         pstart;
    logic [16:0]        received;
    logic               trigger;
    logic               payload_now;
    logic [EARLY_W-1:0] lim;

    t_flow_key          key_eff;
    logic [TBL_W-1:0]   tbl_rdata;
    t_flow_key          tbl_key;
    logic [LEN_W-1:0]   tbl_len;
    logic [CFG_W-1:0]   flows_n;
    logic               lk_last;
    logic [SLOT_W-1:0]  victim;
    logic [SLOT_W-1:0]  ptr_next;

    logic               cnt_re;
    logic [CADDR_W-1:0] cnt_raddr;
    logic               cnt_we;
    logic [CADDR_W-1:0] cnt_waddr;
    logic [CNT_W-1:0]   cnt_wdata;
    logic [CNT_W-1:0]   cnt_rdata;
    logic [7:0]         early_sel;

    t_ent_req           ent_req;
    t_ent_stat          ent_stat;

    assign busy    = (r_state != S_IDLE);
    assign accept  = start && !busy;
    assign in_byte = i_req.packet_byte;

    // header parse of the incoming request
    always_comb begin
        n_key     = r_key;
        n_hdr_len = r_hdr_len;
        if (r_pos == 16'd0) begin
            n_hdr_len = {in_byte[3:0], 2'b00};
        end
        if (r_pos == 16'd9) begin
            n_key.proto = in_byte;
        end
        if (r_pos >= 16'd12 && r_pos <= 16'd15) begin
            n_key.saddr = {r_key.saddr[23:0], in_byte};
        end
        if (r_pos >= 16'd16 && r_pos <= 16'd19) begin
            n_key.daddr = {r_key.daddr[23:0], in_byte};
        end
        port_off = r_pos - {10'd0, n_hdr_len};
        if (r_pos >= {10'd0, n_hdr_len} && port_off < 16'd4) begin
            if (r_pos < 16'(EARLY_BYTES)) begin
                case (port_off[1:0])
                    2'd0:    n_key.sport[15:8] = in_byte;
                    2'd1:    n_key.sport[7:0]  = in_byte;
                    2'd2:    n_key.dport[15:8] = in_byte;
                    default: n_key.dport[7:0]  = in_byte;
                endcase
            end else if (!port_off[1]) begin
                n_key.sport = {r_key.sport[7:0], in_byte};
            end else begin
                n_key.dport = {r_key.dport[7:0], in_byte};
            end
        end
        is_ports = (n_key.proto == PROTO_TCP) || (n_key.proto == PROTO_UDP);
        pstart   = {1'b0, n_hdr_len} +
                   ((n_key.proto == PROTO_TCP) ? TCP_HDR :
                    (n_key.proto == PROTO_UDP) ? UDP_HDR : 7'd0);
        received = {1'b0, r_pos} + 17'd1;
        trigger  = (received >= 17'(EARLY_BYTES)) &&
                   (!is_ports || received >= ({11'd0, n_hdr_len} + 17'd4));
        payload_now = (r_pos >= {9'd0, pstart});
        lim      = (received >= 17'(EARLY_BYTES)) ? EARLY_W'(EARLY_BYTES) : received[EARLY_W-1:0];
    end

    // lookup key and table compare
    always_comb begin
        key_eff = r_key;
        if (!(r_key.proto == PROTO_TCP || r_key.proto == PROTO_UDP)) begin
            key_eff.sport = '0;
            key_eff.dport = '0;
        end
        tbl_key  = r_vld[r_lk_idx] ? tbl_rdata[TBL_W-1:LEN_W] : '0;
        tbl_len  = r_vld[r_lk_idx] ? tbl_rdata[LEN_W-1:0] : '0;
        flows_n  = (r_cfg == '0) ? CFG_W'(1) : (r_cfg > FLOWS_MAX) ? FLOWS_MAX : r_cfg;
        lk_last  = ({1'b0, r_lk_idx} + CFG_W'(1)) >= flows_n;
        victim   = ({1'b0, r_ptr} < flows_n) ? r_ptr : '0;
        ptr_next = (({1'b0, victim} + CFG_W'(1)) >= flows_n) ? '0 : victim + 1'b1;
    end

    // count memory port control
    always_comb begin
        early_sel = (r_eidx < 7'(EARLY_BYTES)) ? r_early[r_eidx[EARLY_W-1:0]] : 8'd0;
        cnt_re    = 1'b0;
        cnt_raddr = {r_slot, in_byte};
        if (r_state == S_ENT) begin
            cnt_re    = ent_stat.rd_en;
            cnt_raddr = {r_slot, ent_stat.rd_idx};
        end else if (r_state == S_IDLE) begin
            cnt_re    = accept && r_looked && payload_now;
        end else if (r_state == S_EC) begin
            cnt_re    = (r_eidx < {2'b00, r_lim});
            cnt_raddr = {r_slot, early_sel};
        end
        cnt_we    = (r_state == S_CNT_WR) || (r_state == S_CLR);
        cnt_waddr = (r_state == S_CLR) ? {r_slot, r_sweep} : r_wr_addr;
        cnt_wdata = (r_state == S_CLR) ? '0 :
                    (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + 1'b1;
        ent_req.start = (r_state == S_FIN);
        ent_req.len   = r_len;
    end

    fpe_ram #(.ADDR_W(CADDR_W), .DATA_W(CNT_W)) u_counts (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_re    (cnt_re),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    fpe_ram #(.ADDR_W(SLOT_W), .DATA_W(TBL_W)) u_flows (
        .i_clk   (i_clk),
        .i_we    (r_state == S_FIN),
        .i_waddr (r_slot),
        .i_wdata ({key_eff, r_len}),
        .i_re    (r_state == S_LK_RD),
        .i_raddr (r_lk_idx),
        .o_rdata (tbl_rdata)
    );

    fpe_entropy u_entropy (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (ent_req),
        .i_rd_data (cnt_rdata),
        .o_stat    (ent_stat)
    );

    // packet sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= FLOWS_RESET;
            r_ptr       <= '0;
            r_pos       <= '0;
            r_hdr_len   <= '0;
            r_key       <= '0;
            r_looked    <= 1'b0;
            r_slot      <= '0;
            r_new       <= 1'b0;
            r_len       <= '0;
            r_vld       <= '0;
            r_last      <= 1'b0;
            r_in_early  <= 1'b0;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (r_pos < 16'(EARLY_BYTES)) begin
                            r_early[r_pos[EARLY_W-1:0]] <= in_byte;
                        end
                        r_key     <= n_key;
                        r_hdr_len <= n_hdr_len;
                        if (r_pos != '1) begin
                            r_pos <= r_pos + 1'b1;
                        end
                        r_last    <= i_req.last_byte;
                        r_wr_addr <= cnt_raddr;
                        if (r_looked) begin
                            if (payload_now) begin
                                r_state <= S_CNT_WR;
                            end else if (i_req.last_byte) begin
                                r_state <= S_FIN;
                            end
                        end else if (trigger || i_req.last_byte) begin
                            r_lk_idx <= '0;
                            r_eidx   <= pstart;
                            r_lim    <= lim;
                            r_state  <= S_LK_RD;
                        end
                    end
                end
                S_LK_RD: r_state <= S_LK_CMP;
                // hit, miss with round-robin victim, or next slot
                S_LK_CMP: begin
                    if (tbl_key == key_eff) begin
                        r_slot   <= r_lk_idx;
                        r_new    <= 1'b0;
                        r_len    <= tbl_len;
                        r_looked <= 1'b1;
                        r_sweep  <= '0;
                        r_state  <= r_vld[r_lk_idx] ? S_EC : S_CLR;
                    end else if (lk_last) begin
                        r_slot   <= victim;
                        r_ptr    <= ptr_next;
                        r_new    <= 1'b1;
                        r_len    <= '0;
                        r_looked <= 1'b1;
                        r_sweep  <= '0;
                        r_state  <= S_CLR;
                    end else begin
                        r_lk_idx <= r_lk_idx + 1'b1;
                        r_state  <= S_LK_RD;
                    end
                end
                S_CLR: begin
                    r_sweep <= r_sweep + 1'b1;
                    if (r_sweep == '1) begin
                        r_state <= S_EC;
                    end
                end
                // payload bytes that arrived before the lookup
                S_EC: begin
                    if (r_eidx < {2'b00, r_lim}) begin
                        r_wr_addr  <= cnt_raddr;
                        r_eidx     <= r_eidx + 1'b1;
                        r_in_early <= 1'b1;
                        r_state    <= S_CNT_WR;
                    end else begin
                        r_in_early <= 1'b0;
                        r_state    <= r_last ? S_FIN : S_IDLE;
                    end
                end
                S_CNT_WR: begin
                    if (r_len != '1) begin
                        r_len <= r_len + 1'b1;
                    end
                    if (r_in_early) begin
                        r_state <= S_EC;
                    end else begin
                        r_state <= r_last ? S_FIN : S_IDLE;
                    end
                end
                S_FIN: begin
                    r_vld[r_slot] <= 1'b1;
                    r_state       <= S_ENT;
                end
                // result strobe and per-packet clear
                S_ENT: begin
                    if (ent_stat.done) begin
                        r_out_valid       <= 1'b1;
                        r_res.entropy_q16 <= ent_stat.q;
                        r_res.flow_slot   <= r_slot;
                        r_res.new_flow    <= r_new;
                        r_pos             <= '0;
                        r_key             <= '0;
                        r_hdr_len         <= '0;
                        r_looked          <= 1'b0;
                        r_new             <= 1'b0;
                        r_last            <= 1'b0;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_res;

`ifndef SYNTHESIS
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |=> !r_out_valid)
        else $error("result strobe held longer than one cycle");
    a_strobe_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $past(r_state == S_ENT))
        else $error("result strobe without entropy pass");
    a_cnt_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cnt_we && cnt_re))
        else $error("count memory read and write in same cycle");
    a_lookup_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LK_RD) |-> !r_looked)
        else $error("second flow lookup in one packet");
    a_ent_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_res.entropy_q16 <= 20'd524288))
        else $error("entropy above eight bits");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import fpe_pkg::*;

    localparam int WATCHDOG_CYCLES = 400000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int RANDOM_BYTES    = 1050;
    localparam logic [7:0] PROTO_ICMP = 8'd1;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    t_in_req          i_req = '0;
    logic             busy;
    logic             o_valid;
    t_out_res         o_res;
    logic             i_cfg_we = 1'b0;
    logic [CFG_W-1:0] i_cfg_wdata = '0;

    flow_payload_entropy_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req      (i_req),
        .busy       (busy),
        .o_valid    (o_valid),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // flow table mirror
    t_flow_key        tbl_key [MAX_FLOWS];
    logic [31:0]      tbl_len [MAX_FLOWS];
    logic [31:0]      bin_cnt [MAX_FLOWS][256];
    int               repl_ptr;
    int               slots_cfg;
    // per-packet parse state
    int               byte_pos;
    t_flow_key        hdr_key;
    int               hdr_len;
    logic [7:0]       head_buf [EARLY_BYTES];
    bit               flow_found;
    int               pkt_slot;
    bit               pkt_new;

    t_out_res         entropy_q[$];
    int               err_cnt = 0;
    int               idle_cycles = 0;
    int               burst_left = 0;
    bit               gaps_on = 1'b1;
    int               rand_bytes = 0;

    function automatic void clear_packet();
        byte_pos = 0;
        hdr_key = '0;
        hdr_len = 0;
        foreach (head_buf[i]) head_buf[i] = 8'h00;
        flow_found = 1'b0;
        pkt_slot = 0;
        pkt_new = 1'b0;
    endfunction

    function automatic bit has_ports();
        return hdr_key.proto == PROTO_TCP || hdr_key.proto == PROTO_UDP;
    endfunction

    function automatic int payload_offset();
        if (hdr_key.proto == PROTO_TCP) return hdr_len + int'(TCP_HDR);
        if (hdr_key.proto == PROTO_UDP) return hdr_len + int'(UDP_HDR);
        return hdr_len;
    endfunction

    function automatic void count_payload(logic [7:0] b);
        if (bin_cnt[pkt_slot][b] != 32'hFFFF_FFFF) bin_cnt[pkt_slot][b]++;
        if (tbl_len[pkt_slot] != 32'hFFFF_FFFF) tbl_len[pkt_slot]++;
    endfunction

    function automatic int slots_in_use();
        if (slots_cfg < 1) return 1;
        if (slots_cfg > MAX_FLOWS) return MAX_FLOWS;
        return slots_cfg;
    endfunction

    // five-tuple search, replacement and catch-up of buffered payload
    function automatic void flow_lookup(int received);
        t_flow_key k;
        int n, s, lim;
        bit hit;
        k = hdr_key;
        n = slots_in_use();
        hit = 1'b0;
        if (has_ports()) begin
            if (hdr_len + 4 <= EARLY_BYTES) begin
                k.sport = {head_buf[hdr_len], head_buf[hdr_len+1]};
                k.dport = {head_buf[hdr_len+2], head_buf[hdr_len+3]};
            end
        end else begin
            k.sport = '0;
            k.dport = '0;
        end
        for (s = 0; s < n; s++) begin
            if (tbl_key[s] == k) begin
                hit = 1'b1;
                break;
            end
        end
        if (!hit) begin
            s = (repl_ptr < n) ? repl_ptr : 0;
            tbl_key[s] = k;
            for (int j = 0; j < 256; j++) bin_cnt[s][j] = '0;
            tbl_len[s] = '0;
            repl_ptr = (s + 1 >= n) ? 0 : s + 1;
        end
        pkt_slot = s;
        pkt_new = !hit;
        flow_found = 1'b1;
        lim = received < EARLY_BYTES ? received : EARLY_BYTES;
        for (int j = payload_offset(); j < lim; j++) count_payload(head_buf[j]);
    endfunction

    // log2 in q5.24 by repeated squaring, truncating
    function automatic logic [28:0] log2_q24(logic [31:0] v);
        int k;
        logic [63:0] x;
        logic [23:0] frac;
        k = 31;
        frac = '0;
        while (k > 0 && !v[k]) k--;
        x = 64'(v) << (31 - k);
        for (int i = 0; i < LOG_FRAC; i++) begin
            x = (x * x) >> 31;
            frac = frac << 1;
            if (x >= 64'h1_0000_0000) begin
                x = x >> 1;
                frac[0] = 1'b1;
            end
        end
        return {5'(k), frac};
    endfunction

    function automatic logic [ENT_W-1:0] flow_entropy(int s);
        logic [31:0] len, logl, d;
        logic [63:0] acc, r;
        len = tbl_len[s];
        acc = '0;
        if (len == 0) return '0;
        logl = 32'(log2_q24(len));
        for (int i = 0; i < 256; i++) begin
            if (bin_cnt[s][i] != 0 && bin_cnt[s][i] < len) begin
                d = logl - 32'(log2_q24(bin_cnt[s][i]));
                acc += (64'(bin_cnt[s][i]) * 64'(d)) / 64'(len);
            end
        end
        if (acc > (64'd8 << LOG_FRAC)) acc = 64'd8 << LOG_FRAC;
        r = (acc + (64'd1 << (LOG_FRAC - FRAC_BITS - 1))) >> (LOG_FRAC - FRAC_BITS);
        if (r > 64'hFFFFF) r = 64'hFFFFF;
        return r[ENT_W-1:0];
    endfunction

    // advance the mirror by one accepted byte
    function automatic void predict_byte(logic [7:0] b, logic last);
        int pos, received;
        t_out_res res;
        pos = byte_pos;
        received = pos + 1;
        if (pos < EARLY_BYTES) head_buf[pos] = b;
        if (pos == 0) hdr_len = int'(b[3:0]) * 4;
        else if (pos == 9) hdr_key.proto = b;
        else if (pos >= 12 && pos <= 15) hdr_key.saddr = {hdr_key.saddr[23:0], b};
        else if (pos >= 16 && pos <= 19) hdr_key.daddr = {hdr_key.daddr[23:0], b};
        if (pos >= EARLY_BYTES && pos >= hdr_len && pos < hdr_len + 4) begin
            if (pos < hdr_len + 2) hdr_key.sport = {hdr_key.sport[7:0], b};
            else hdr_key.dport = {hdr_key.dport[7:0], b};
        end
        if (flow_found) begin
            if (pos >= payload_offset()) count_payload(b);
        end else if (received >= EARLY_BYTES && (!has_ports() || received >= hdr_len + 4)) begin
            flow_lookup(received);
        end
        if (byte_pos < 65535) byte_pos++;
        if (last) begin
            if (!flow_found) flow_lookup(received);
            res.entropy_q16 = flow_entropy(pkt_slot);
            res.flow_slot = SLOT_W'(pkt_slot);
            res.new_flow = pkt_new;
            entropy_q.push_back(res);
            clear_packet();
        end
    endfunction

    // check each result strobe against the oldest expectation
    always @(posedge i_clk) begin
        t_out_res want;
        if (i_rst_n && o_valid) begin
            if (entropy_q.size() == 0) begin
                $display("%0t: unexpected result entropy=%h slot=%0d new=%0b",
                         $time, o_res.entropy_q16, o_res.flow_slot, o_res.new_flow);
                err_cnt++;
            end else begin
                want = entropy_q.pop_front();
                if (o_res.entropy_q16 !== want.entropy_q16) begin
                    $display("%0t: entropy expected %h actual %h",
                             $time, want.entropy_q16, o_res.entropy_q16);
                    err_cnt++;
                end
                if (o_res.flow_slot !== want.flow_slot) begin
                    $display("%0t: flow_slot expected %0d actual %0d",
                             $time, want.flow_slot, o_res.flow_slot);
                    err_cnt++;
                end
                if (o_res.new_flow !== want.new_flow) begin
                    $display("%0t: new_flow expected %0b actual %0b",
                             $time, want.new_flow, o_res.new_flow);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog on cycles without any request or result
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // send one request, with bursty gaps in front
    task automatic send_byte(logic [7:0] b, logic last);
        if (gaps_on && burst_left == 0) begin
            start = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        start = 1'b1;
        i_req.packet_byte = b;
        i_req.last_byte = last;
        do @(posedge i_clk); while (busy);
        predict_byte(b, last);
        if (burst_left > 0) burst_left--;
        @(negedge i_clk);
        start = 1'b0;
    endtask

    task automatic send_packet(const ref logic [7:0] pkt[$]);
        foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
    endtask

    task automatic wait_drained();
        while (entropy_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_slots(logic [CFG_W-1:0] v);
        wait_drained();
        i_cfg_we = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        slots_cfg = int'(v);
    endtask

    // build an ipv4 packet; plen < 0 keeps the full length
    task automatic build_packet(output logic [7:0] pkt[$], input logic [3:0] ihl,
                                input logic [7:0] proto, input logic [31:0] sa,
                                input logic [31:0] da, input logic [15:0] sp,
                                input logic [15:0] dp, input int pay_len,
                                input int alphabet, input int plen);
        int hl;
        pkt = {};
        hl = int'(ihl) * 4;
        for (int i = 0; i < 20; i++) pkt.push_back(8'($urandom));
        pkt[0] = {4'h4, ihl};
        pkt[9] = proto;
        {pkt[12], pkt[13], pkt[14], pkt[15]} = sa;
        {pkt[16], pkt[17], pkt[18], pkt[19]} = da;
        while (pkt.size() < hl) pkt.push_back(8'($urandom));
        if (proto == PROTO_TCP || proto == PROTO_UDP) begin
            while (pkt.size() < hl + 4) pkt.push_back(8'h00);
            {pkt[hl], pkt[hl+1], pkt[hl+2], pkt[hl+3]} = {sp, dp};
            while (pkt.size() < hl + ((proto == PROTO_TCP) ? 20 : 8))
                pkt.push_back(8'($urandom));
        end
        repeat (pay_len) pkt.push_back(8'($urandom_range(0, alphabet - 1)));
        if (plen >= 1 && plen < pkt.size()) pkt = pkt[0:plen-1];
    endtask

    // all-zero key on a fresh table matches slot 0 without replacing it
    task automatic test_cleared_table();
        logic [7:0] pkt[$];
        build_packet(pkt, 4'd5, 8'd0, '0, '0, '0, '0, 0, 256, -1);
        foreach (pkt[i]) pkt[i] = 8'h00;
        pkt[0] = 8'h45;
        send_packet(pkt);
    endtask

    // header extremes, each protocol, short packets, early payload
    task automatic test_directed();
        logic [7:0] pkt[$];
        build_packet(pkt, 4'd5, PROTO_TCP, 32'hFFFF_FFFF, 32'h0000_0000,
                     16'hFFFF, 16'h0000, 12, 256, -1);
        send_packet(pkt);
        send_packet(pkt);
        build_packet(pkt, 4'd15, PROTO_UDP, 32'h0A00_0001, 32'hFFFF_FFFF,
                     16'h0035, 16'hFFFF, 10, 256, -1);
        send_packet(pkt);
        build_packet(pkt, 4'd5, PROTO_ICMP, 32'h0A00_0002, 32'h0A00_0003,
                     '0, '0, 0, 256, -1);
        send_packet(pkt);
        build_packet(pkt, 4'd0, PROTO_TCP, 32'h0102_0304, 32'h0506_0708,
                     '0, '0, 6, 256, -1);
        send_packet(pkt);
        build_packet(pkt, 4'd2, 8'hFF, 32'h0102_0304, 32'h0506_0708,
                     '0, '0, 6, 2, -1);
        send_packet(pkt);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        build_packet(pkt, 4'd5, PROTO_UDP, 32'hC0A8_0001, 32'hC0A8_0002,
                     16'h1234, 16'h5678, 4, 256, 22);
        send_packet(pkt);
        build_packet(pkt, 4'd15, PROTO_TCP, 32'hC0A8_0001, 32'hC0A8_0002,
                     16'h1234, 16'h5678, 4, 256, 40);
        send_packet(pkt);
    endtask

    // random flows, mostly well formed, from small address and port pools
    task automatic random_packet();
        logic [7:0] pkt[$];
        logic [3:0] ihl;
        logic [7:0] proto;
        logic [31:0] sa, da;
        logic [15:0] sp, dp;
        int sel, plen;
        sel = $urandom_range(0, 9);
        ihl = (sel < 7) ? 4'd5 : 4'($urandom);
        sel = $urandom_range(0, 9);
        proto = (sel < 4) ? PROTO_TCP : (sel < 7) ? PROTO_UDP :
                (sel < 9) ? PROTO_ICMP : 8'($urandom);
        sa = ($urandom_range(0, 7) == 0) ? 32'($urandom) : 32'h0A00_0000 + $urandom_range(0, 3);
        da = ($urandom_range(0, 7) == 0) ? 32'($urandom) : 32'h0A01_0000 + $urandom_range(0, 2);
        sp = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'(1000 + $urandom_range(0, 2));
        dp = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'(80 + $urandom_range(0, 1));
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 30) : -1;
        build_packet(pkt, ihl, proto, sa, da, sp, dp, $urandom_range(0, 24),
                     ($urandom_range(0, 3) == 0) ? 256 : 16, plen);
        gaps_on = ($urandom_range(0, 4) != 0);
        send_packet(pkt);
        rand_bytes += pkt.size();
    endtask

    task automatic test_random_phase(logic [CFG_W-1:0] slots, int budget);
        int stop_at;
        write_slots(slots);
        stop_at = rand_bytes + budget;
        while (rand_bytes < stop_at) random_packet();
    endtask

    initial begin
        foreach (tbl_key[s]) begin
            tbl_key[s] = '0;
            tbl_len[s] = '0;
            for (int j = 0; j < 256; j++) bin_cnt[s][j] = '0;
        end
        repl_ptr = 0;
        slots_cfg = int'(FLOWS_RESET);
        clear_packet();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_cleared_table();
        test_directed();
        test_random_phase(FLOWS_MAX, 170);
        test_random_phase(5'd3, 100);
        test_random_phase(5'd1, 70);
        test_random_phase(5'd0, 70);
        test_random_phase(5'd31, 100);
        test_random_phase(5'd17, 70);
        test_random_phase(5'd7, 130);

        wait_drained();
        if (err_cnt == 0) $display("tb_top: done, clean");
        else $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ===== flow_payload_entropy_top.f =====
rtl/fpe_pkg.sv
rtl/fpe_ram.sv
rtl/fpe_log2.sv
rtl/fpe_entropy.sv
rtl/flow_payload_entropy_top.sv
tb/tb_top.sv
